// ----- hw/rtl/y86_execute_alu_with_flags_defines.svh -----
// Assertion macros for the execute stage.
`ifndef Y86_EXECUTE_ALU_WITH_FLAGS_DEFINES_SVH
`define Y86_EXECUTE_ALU_WITH_FLAGS_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define Y86X_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define Y86X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/y86x_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package y86x_pkg;

  localparam int WordW = 64;
  localparam int ShamtW = 6;
  localparam int InDataW = 200;
  localparam int OutDataW = 72;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [3:0] {
    CLS_OTHER = 4'd0,
    CLS_RRMOV = 4'd1,
    CLS_IRMOV = 4'd2,
    CLS_RMMOV = 4'd3,
    CLS_MRMOV = 4'd4,
    CLS_OP    = 4'd5,
    CLS_CALL  = 4'd6,
    CLS_PUSH  = 4'd7,
    CLS_RET   = 4'd8,
    CLS_POP   = 4'd9
  } instr_class_t;

  typedef enum logic [3:0] {
    FUN_ADD = 4'd0,
    FUN_SUB = 4'd1,
    FUN_AND = 4'd2,
    FUN_XOR = 4'd3,
    FUN_SHL = 4'd4,
    FUN_SHR = 4'd5
  } alu_fun_t;

  // Stack pointer step for call/push (-8) and ret/pop (+8).
  localparam word_t StackDec = word_t'(-64'sd8);
  localparam word_t StackInc = word_t'(64'd8);

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
  } cc_t;

  localparam cc_t CcReset = '{of: 1'b0, sf: 1'b0, zf: 1'b1};

  // One decoded item as held in the input register.
  typedef struct packed {
    word_t      val_c;
    word_t      val_b;
    word_t      val_a;
    logic [3:0] alu_fun;
    logic [3:0] instr_class;
  } ex_req_t;

  // ALU result and the condition codes it would write.
  typedef struct packed {
    word_t val_e;
    cc_t   cc;
    logic  cc_write;
  } alu_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/y86x_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module y86x_alu
  import y86x_pkg::*;
(
  input  ex_req_t  req,
  output alu_res_t res
);

  word_t              op_a;
  word_t              op_b;
  logic [3:0]         fun;
  logic [ShamtW-1:0]  shamt;
  logic               big_shift;
  word_t              e;
  logic               of;
  logic               known;

  // Operand A select
  always_comb begin
    case (req.instr_class)
      CLS_RRMOV, CLS_OP:              op_a = req.val_a;
      CLS_IRMOV, CLS_RMMOV, CLS_MRMOV: op_a = req.val_c;
      CLS_CALL, CLS_PUSH:             op_a = StackDec;
      CLS_RET, CLS_POP:               op_a = StackInc;
      default:                        op_a = '0;
    endcase
  end

  assign op_b = (req.instr_class inside {[CLS_RMMOV:CLS_POP]}) ? req.val_b : '0;

  // Non-op classes always add.
  assign fun = (req.instr_class == CLS_OP) ? req.alu_fun : FUN_ADD;

  assign shamt     = op_b[ShamtW-1:0];
  assign big_shift = |op_b[WordW-1:ShamtW];

  always_comb begin
    e     = '0;
    of    = 1'b0;
    known = 1'b1;
    case (fun)
      FUN_ADD: begin
        e  = op_a + op_b;
        of = (op_a[WordW-1] ~^ op_b[WordW-1]) & (e[WordW-1] ^ op_a[WordW-1]);
      end
      FUN_SUB: begin
        e  = op_b - op_a;
        of = (op_b[WordW-1] ^ op_a[WordW-1]) & (op_b[WordW-1] ^ e[WordW-1]);
      end
      FUN_AND: e = op_a & op_b;
      FUN_XOR: e = op_a ^ op_b;
      FUN_SHL: begin
        if (big_shift) begin
          e  = '0;
          of = 1'b1;
        end else begin
          e  = op_a << shamt;
          // bit (63 - n) of A; for a 6-bit n that index is ~n
          of = op_a[~shamt];
        end
      end
      FUN_SHR: begin
        if (big_shift) e = {WordW{op_a[WordW-1]}};
        else           e = word_t'($signed(op_a) >>> shamt);
      end
      default: known = 1'b0;
    endcase
  end

  assign res.val_e    = e;
  assign res.cc.zf    = (e == '0);
  assign res.cc.sf    = e[WordW-1];
  assign res.cc.of    = of;
  assign res.cc_write = (req.instr_class == CLS_OP) & known;

endmodule

`default_nettype wire

// ----- hw/rtl/y86x_flags.sv -----
`timescale 1ns / 1ps
`default_nettype none

module y86x_flags
  import y86x_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_res_t res,
  input  logic     commit,
  output cc_t      cc_show,
  output cc_t      cc
);

  // Flags the committing item reports: its own if it writes, else the stored ones.
  assign cc_show = res.cc_write ? res.cc : cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= CcReset;
    end else if (commit) begin
      cc <= cc_show;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/y86_execute_alu_with_flags.sv -----
// Y86-64 execute stage: operand select, ALU and condition codes.
// Input stream (s_*): one request per instruction with class, function
// code and the three 64-bit operands. Output stream (m_*): the ALU result
// and the ZF/SF/OF condition codes as they stand after that instruction.
// Only op-class requests with a known function code write the stored
// codes; every other request reports the stored codes unchanged.
// An accepted request is held in the input register, then in the result
// register, which drives m_tvalid. Throughput: one request per cycle
// unless the receiver stalls; the ALU between the two registers is a
// single pass of operand muxes, a 64-bit add/logic/shift and a zero test.
// Reset clears both valid bits and sets the codes to ZF=1, SF=0, OF=0.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, then s_tready drops until the result moves.
`timescale 1ns / 1ps
`default_nettype none

`include "y86_execute_alu_with_flags_defines.svh"

module y86_execute_alu_with_flags
  import y86x_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // instr_class[3:0], alu_fun[7:4], val_a[71:8], val_b[135:72], val_c[199:136]
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // val_e[63:0], zero_flag[64], sign_flag[65], overflow_flag[66], zero pad[71:67]
  output logic [OutDataW-1:0] m_tdata
);

  localparam int PadW = OutDataW - WordW - 3;

  ex_req_t  in_req;
  logic     in_valid;
  logic     in_ready;
  logic     out_load;
  alu_res_t alu_res;
  cc_t      cc_show;
  cc_t      cc;
  word_t    out_val_e;
  cc_t      out_cc;

  // Result register frees up when empty or being taken this cycle.
  assign out_load = in_valid & (~m_tvalid | m_tready);
  assign in_ready = ~in_valid | ~m_tvalid | m_tready;
  assign s_tready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_tvalid) begin
      in_req <= ex_req_t'(s_tdata);
    end
  end

  y86x_alu u_alu (
    .req (in_req),
    .res (alu_res)
  );

  // Condition codes commit in request order, as each result is registered.
  y86x_flags u_flags (
    .clk     (clk),
    .rst     (rst),
    .res     (alu_res),
    .commit  (out_load),
    .cc_show (cc_show),
    .cc      (cc)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (~m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_e <= alu_res.val_e;
      out_cc    <= cc_show;
    end
  end

  assign m_tdata = {{PadW{1'b0}}, out_cc.of, out_cc.sf, out_cc.zf, out_val_e};

  // Reported flags always match the stored codes once a result is held.
  `Y86X_ASSERT_ALWAYS(a_flags_match_cc, !m_tvalid || (out_cc == cc), "output flags differ from stored codes")
  // Stored codes change only when a result is registered.
  `Y86X_ASSERT_NEXT(a_cc_hold, !out_load, $stable(cc), "condition codes changed without a commit")
  // An empty result register never blocks the input side.
  `Y86X_ASSERT_ALWAYS(a_ready_when_empty, m_tvalid || s_tready, "input stalled with empty output")

endmodule

`default_nettype wire
